FILE: hdl/mwm_pkg.sv
// Shared types and constants for the mecanum wheel mixer.
package mwm_pkg;

    localparam int CMD_W       = 16;
    localparam int SPEED_W     = 8;
    localparam int DUTY_W      = 8;
    localparam int MIX_W       = CMD_W + 2;
    localparam int AM_W        = CMD_W + 1;
    localparam int NUM_W       = AM_W + SPEED_W;
    localparam int NWHEEL      = 4;
    localparam int DIV_BITS    = 2;
    localparam int DIV_STAGES  = DUTY_W / DIV_BITS;

    localparam int WHEEL_FR = 0;
    localparam int WHEEL_FL = 1;
    localparam int WHEEL_RR = 2;
    localparam int WHEEL_RL = 3;

    localparam logic [SPEED_W-1:0] SPEED_RESET = 8'd255;

    typedef struct packed {
        logic signed [CMD_W-1:0] drive_cmd;
        logic signed [CMD_W-1:0] turn_cmd;
        logic signed [CMD_W-1:0] strafe_cmd;
    } t_cmd_in;

    typedef struct packed {
        logic [DUTY_W-1:0] duty_front_right;
        logic [DUTY_W-1:0] duty_front_left;
        logic [DUTY_W-1:0] duty_rear_right;
        logic [DUTY_W-1:0] duty_rear_left;
        logic              dir_front_right;
        logic              dir_front_left;
        logic              dir_rear_right;
        logic              dir_rear_left;
    } t_mix_out;

endpackage

FILE: hdl/mwm_divider.sv
// Pipelined restoring divider, two quotient bits per stage, quotient below 2**DUTY_W.
module mwm_divider (
    input  logic                       i_clk,
    input  logic [mwm_pkg::NUM_W-1:0]  i_num,
    input  logic [mwm_pkg::AM_W-1:0]   i_den,
    output logic [mwm_pkg::DUTY_W-1:0] o_quo
);
    import mwm_pkg::*;

    logic [NUM_W-1:0]  r_rem [DIV_STAGES];
    logic [AM_W-1:0]   r_den [DIV_STAGES];
    logic [DUTY_W-1:0] r_quo [DIV_STAGES];

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        localparam int B_HI = DUTY_W - 1 - DIV_BITS * k;
        localparam int B_LO = B_HI - 1;

        logic [NUM_W-1:0]  rem_in;
        logic [AM_W-1:0]   den_in;
        logic [DUTY_W-1:0] quo_in;
        logic [NUM_W-1:0]  sub_hi;
        logic [NUM_W-1:0]  sub_lo;
        logic [NUM_W-1:0]  rem_mid;
        logic [NUM_W-1:0]  n_rem;
        logic [DUTY_W-1:0] n_quo;

        if (k == 0) begin : g_first
            assign rem_in = i_num;
            assign den_in = i_den;
            assign quo_in = '0;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign den_in = r_den[k-1];
            assign quo_in = r_quo[k-1];
        end

        always_comb begin
            sub_hi = NUM_W'(den_in) << B_HI;
            sub_lo = NUM_W'(den_in) << B_LO;
            n_quo  = quo_in;
            if (rem_in >= sub_hi) begin
                rem_mid     = rem_in - sub_hi;
                n_quo[B_HI] = 1'b1;
            end else begin
                rem_mid = rem_in;
            end
            if (rem_mid >= sub_lo) begin
                n_rem       = rem_mid - sub_lo;
                n_quo[B_LO] = 1'b1;
            end else begin
                n_rem = rem_mid;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k] <= n_rem;
            r_den[k] <= den_in;
            r_quo[k] <= n_quo;
        end
    end

    assign o_quo = r_quo[DIV_STAGES-1];

endmodule

FILE: hdl/mecanum_wheel_mixer_top.sv
// Mecanum wheel mixer: mixes drive, turn and strafe into four wheel duties and directions.
// Pipeline: a command taken with start runs through three front stages, four divider stages
// and an output register, and its result appears with o_strobe high.
// Throughput: one command per cycle, busy stays low; the normalising divider is fully pipelined.
// Reset (synchronous, active low) empties the pipeline and sets max_speed to 255.
module mecanum_wheel_mixer_top #(
    parameter int COMMAND_FRAC_BITS = 14
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  mwm_pkg::t_cmd_in             i_cmd,
    output logic                         o_strobe,
    output mwm_pkg::t_mix_out            o_result,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [mwm_pkg::SPEED_W-1:0]  i_cfg_data
);
    import mwm_pkg::*;

    localparam int CMP_W = (COMMAND_FRAC_BITS + 2 > AM_W) ? COMMAND_FRAC_BITS + 2 : AM_W;
    localparam logic [CMP_W-1:0] UNIT = CMP_W'(1) << COMMAND_FRAC_BITS;

    logic [SPEED_W-1:0] r_max_speed;

    // stage A: mixes
    logic                    r_a_vld;
    logic signed [MIX_W-1:0] r_a_mix [NWHEEL];
    logic [SPEED_W-1:0]      r_a_ms;
    // stage B: magnitudes and directions
    logic                    r_b_vld;
    logic [AM_W-1:0]         r_b_am [NWHEEL];
    logic [NWHEEL-1:0]       r_b_dir;
    logic [SPEED_W-1:0]      r_b_ms;
    // stage C: products, largest magnitude, rescale flag
    logic                    r_c_vld;
    logic [NUM_W-1:0]        r_c_prod [NWHEEL];
    logic [AM_W-1:0]         r_c_big;
    logic                    r_c_scale;
    logic [NWHEEL-1:0]       r_c_dir;
    // side band alongside the divider
    logic                    r_d_vld   [DIV_STAGES];
    logic                    r_d_scale [DIV_STAGES];
    logic [NWHEEL-1:0]       r_d_dir   [DIV_STAGES];
    logic [DUTY_W-1:0]       r_d_nr    [DIV_STAGES][NWHEEL];
    // output register
    logic                    r_o_vld;
    t_mix_out                r_o;

    logic                    accept;
    logic signed [MIX_W-1:0] d_x, t_x, s_x;
    logic signed [MIX_W-1:0] n_mix [NWHEEL];
    logic [AM_W-1:0]         n_am [NWHEEL];
    logic [NWHEEL-1:0]       n_dir;
    logic [AM_W-1:0]         big_lo, big_hi, n_big;
    logic [DUTY_W-1:0]       quo [NWHEEL];
    logic [DUTY_W-1:0]       n_duty [NWHEEL];
    t_mix_out                n_o;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_speed <= SPEED_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_max_speed <= i_cfg_data;
        end
    end

    always_comb begin
        d_x = MIX_W'(i_cmd.drive_cmd);
        t_x = MIX_W'(i_cmd.turn_cmd);
        s_x = MIX_W'(i_cmd.strafe_cmd);
        n_mix[WHEEL_FR] = d_x + t_x + s_x;
        n_mix[WHEEL_FL] = d_x - t_x - s_x;
        n_mix[WHEEL_RR] = d_x + t_x - s_x;
        n_mix[WHEEL_RL] = d_x - t_x + s_x;
    end

    always_comb begin
        for (int i = 0; i < NWHEEL; i++) begin
            n_am[i]  = r_a_mix[i][MIX_W-1] ? AM_W'(-r_a_mix[i]) : AM_W'(r_a_mix[i]);
            n_dir[i] = (r_a_mix[i] > 0) && (r_a_ms != '0);
        end
        // left wheels run mirrored
        n_dir[WHEEL_FL] = !n_dir[WHEEL_FL];
        n_dir[WHEEL_RL] = !n_dir[WHEEL_RL];
    end

    always_comb begin
        big_lo = (r_b_am[0] > r_b_am[1]) ? r_b_am[0] : r_b_am[1];
        big_hi = (r_b_am[2] > r_b_am[3]) ? r_b_am[2] : r_b_am[3];
        n_big  = (big_lo > big_hi) ? big_lo : big_hi;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            for (int k = 0; k < DIV_STAGES; k++) begin
                r_d_vld[k] <= 1'b0;
            end
            r_o_vld <= 1'b0;
        end else begin
            r_a_vld    <= accept;
            r_b_vld    <= r_a_vld;
            r_c_vld    <= r_b_vld;
            r_d_vld[0] <= r_c_vld;
            for (int k = 1; k < DIV_STAGES; k++) begin
                r_d_vld[k] <= r_d_vld[k-1];
            end
            r_o_vld <= r_d_vld[DIV_STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_mix <= n_mix;
        r_a_ms  <= r_max_speed;

        r_b_am  <= n_am;
        r_b_dir <= n_dir;
        r_b_ms  <= r_a_ms;

        for (int i = 0; i < NWHEEL; i++) begin
            r_c_prod[i] <= NUM_W'(r_b_am[i]) * NUM_W'(r_b_ms);
        end
        r_c_big   <= n_big;
        // rescale when some wheel would pass max_speed, i.e. largest mix above one
        r_c_scale <= (r_b_ms != '0) && (CMP_W'(n_big) > UNIT);
        r_c_dir   <= r_b_dir;

        r_d_scale[0] <= r_c_scale;
        r_d_dir[0]   <= r_c_dir;
        for (int i = 0; i < NWHEEL; i++) begin
            r_d_nr[0][i] <= DUTY_W'(r_c_prod[i] >> COMMAND_FRAC_BITS);
        end
        for (int k = 1; k < DIV_STAGES; k++) begin
            r_d_scale[k] <= r_d_scale[k-1];
            r_d_dir[k]   <= r_d_dir[k-1];
            r_d_nr[k]    <= r_d_nr[k-1];
        end

        r_o <= n_o;
    end

    for (genvar w = 0; w < NWHEEL; w++) begin : g_div
        mwm_divider u_div (
            .i_clk (i_clk),
            .i_num (r_c_prod[w]),
            .i_den (r_c_big),
            .o_quo (quo[w])
        );
    end

    always_comb begin
        for (int i = 0; i < NWHEEL; i++) begin
            n_duty[i] = r_d_scale[DIV_STAGES-1] ? quo[i] : r_d_nr[DIV_STAGES-1][i];
        end
        n_o.duty_front_right = n_duty[WHEEL_FR];
        n_o.duty_front_left  = n_duty[WHEEL_FL];
        n_o.duty_rear_right  = n_duty[WHEEL_RR];
        n_o.duty_rear_left   = n_duty[WHEEL_RL];
        n_o.dir_front_right  = r_d_dir[DIV_STAGES-1][WHEEL_FR];
        n_o.dir_front_left   = r_d_dir[DIV_STAGES-1][WHEEL_FL];
        n_o.dir_rear_right   = r_d_dir[DIV_STAGES-1][WHEEL_RR];
        n_o.dir_rear_left    = r_d_dir[DIV_STAGES-1][WHEEL_RL];
    end

    assign o_strobe = r_o_vld;
    assign o_result = r_o;

endmodule
